@@ design/itrd_pkg.sv @@
// Shared types, register map and helpers for the radix digit converter.
package itrd_pkg;

    // Configuration port geometry: 64-bit registers at 8-byte strides
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 5;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_RADIX      = 2'd0;
    localparam logic [1:0] REG_CHARS_LOW  = 2'd1;
    localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

    // Register reset values
    localparam logic [4:0]  RADIX_RST      = 5'd10;
    localparam logic [63:0] CHARS_LOW_RST  = 64'h3736_3534_3332_3130; // "01234567"
    localparam logic [63:0] CHARS_HIGH_RST = 64'h6665_6463_6261_3938; // "89abcdef"

    // Broadcast control from the sequencer to every cell of the row
    typedef struct packed {
        logic clear;  // zero the digit, drop any conversion in flight
        logic shift;  // move digits one cell toward the top
    } t_cell_ctrl;

    // Character lookup in the 16-entry digit table
    function automatic logic [7:0] char_of(
        input logic [3:0]  d,
        input logic [63:0] chars_low,
        input logic [63:0] chars_high
    );
        logic [63:0] sel;
        sel = d[3] ? chars_high : chars_low;
        return sel[{d[2:0], 3'b000} +: 8];
    endfunction

endpackage

@@ design/integer_to_radix_digits_core.sv @@
// Top level: value to radix digit characters, most significant digit first.
//
// Converts an unsigned or signed (magnitude taken) value into digits of the
// configured radix and sends one item per digit, most significant first, each
// carrying its table character, the total digit count and a last flag. The
// conversion runs through a row of VALUE_BITS digit cells: value bits enter
// the bottom cell MSB first, one per cycle, and each cell registers the carry
// it hands to the next one. The row then shifts toward the top cell, first
// skipping leading zeros and then emitting one digit per unstalled cycle,
// VALUE_BITS shifts in all; the skip phase ends without a shift. One item is
// in work at a time: the next is taken only once the last digit has gone out.
// With radix below two an item is taken and dropped; radix above MAX_RADIX is
// used as MAX_RADIX.
module integer_to_radix_digits_core
    import itrd_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned MAX_RADIX  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [63:0]           i_value_bits,
    input  logic                  i_mode,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_digit_char,
    output logic [6:0]            o_digit_count,
    output logic                  o_last,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned NCELLS  = VALUE_BITS;
    localparam int unsigned DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int unsigned CNT_W   = $clog2(2 * VALUE_BITS);
    localparam logic [CNT_W-1:0] FEED_LEN  = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_BITS + NCELLS - 2);
    localparam logic [CNT_W-1:0] SKIP_MAX  = CNT_W'(NCELLS - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [4:0]            r_radix;
    logic [63:0]           r_chars_low;
    logic [63:0]           r_chars_high;
    logic [1:0]            r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_BITS-1:0] r_val;
    logic [6:0]            r_count;
    logic [6:0]            r_idx;

    logic                  w_cfg_wr;
    logic [1:0]            w_cfg_idx;
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic [DIGIT_W:0]      w_radix_eff;
    logic [VALUE_BITS-1:0] w_value;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_feed;
    logic [DIGIT_W-1:0]    w_top;
    logic                  w_top_zero;
    t_cell_ctrl            w_ctrl;

    logic                  w_en    [NCELLS];
    logic                  w_carry [NCELLS];
    logic [DIGIT_W-1:0]    w_digit [NCELLS];

    // Configuration registers
    assign w_cfg_idx = paddr[4:3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix      <= RADIX_RST;
            r_chars_low  <= CHARS_LOW_RST;
            r_chars_high <= CHARS_HIGH_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_RADIX:      r_radix      <= pwdata[4:0];
                REG_CHARS_LOW:  r_chars_low  <= pwdata;
                REG_CHARS_HIGH: r_chars_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_RADIX:      prdata = {59'd0, r_radix};
            REG_CHARS_LOW:  prdata = r_chars_low;
            REG_CHARS_HIGH: prdata = r_chars_high;
            default:        prdata = '0;
        endcase
    end

    // Saturated radix for the cells
    assign w_radix_eff = (r_radix > 5'(MAX_RADIX)) ? (DIGIT_W + 1)'(MAX_RADIX)
                                                   : (DIGIT_W + 1)'(r_radix);

    // Magnitude of the incoming value
    assign w_value = i_value_bits[VALUE_BITS-1:0];
    assign w_mag   = (i_mode && w_value[VALUE_BITS-1]) ? (~w_value + 1'b1) : w_value;

    // Handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_EMIT);
    assign w_out_acc   = o_out_valid && !i_out_stall;

    assign w_feed     = (r_state == ST_CONV) && (r_cnt < FEED_LEN);
    assign w_top      = w_digit[NCELLS-1];
    assign w_top_zero = (w_top == '0);

    // Row control
    always_comb begin
        w_ctrl.clear = w_in_acc;
        w_ctrl.shift = ((r_state == ST_SCAN) && w_top_zero && (r_cnt < SKIP_MAX))
                       || w_out_acc;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (r_radix >= 5'd2)) begin
                        r_state <= ST_CONV;
                        r_cnt   <= '0;
                    end
                end
                ST_CONV: begin
                    if (r_cnt == CONV_LAST) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (w_top_zero && (r_cnt < SKIP_MAX)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= ST_EMIT;
                        r_count <= 7'(NCELLS) - 7'(r_cnt);
                        r_idx   <= '0;
                    end
                end
                ST_EMIT: begin
                    if (w_out_acc) begin
                        r_idx <= r_idx + 1'b1;
                        if (o_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Value bits, MSB first into the bottom cell
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_val <= w_mag;
        end else if (w_feed) begin
            r_val <= {r_val[VALUE_BITS-2:0], 1'b0};
        end
    end

    // Row of digit cells, cell 0 least significant
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        if (g == 0) begin : g_first
            itrd_cell #(.DIGIT_W(DIGIT_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_radix (w_radix_eff),
                .i_en    (w_feed),
                .i_carry (r_val[VALUE_BITS-1]),
                .i_digit ('0),
                .o_en    (w_en[g]),
                .o_carry (w_carry[g]),
                .o_digit (w_digit[g])
            );
        end else begin : g_next
            itrd_cell #(.DIGIT_W(DIGIT_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_radix (w_radix_eff),
                .i_en    (w_en[g-1]),
                .i_carry (w_carry[g-1]),
                .i_digit (w_digit[g-1]),
                .o_en    (w_en[g]),
                .o_carry (w_carry[g]),
                .o_digit (w_digit[g])
            );
        end
    end

    // Output character straight from the top cell, count and last flag from the sequencer
    assign o_digit_char  = char_of(4'(w_top), r_chars_low, r_chars_high);
    assign o_digit_count = r_count;
    assign o_last        = (r_idx == (r_count - 7'd1));

endmodule

@@ design/itrd_cell.sv @@
// One digit cell: doubles its digit plus incoming carry modulo the radix.
module itrd_cell
    import itrd_pkg::*;
#(
    parameter int unsigned DIGIT_W = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [DIGIT_W:0]   i_radix,
    input  logic               i_en,
    input  logic               i_carry,
    input  logic [DIGIT_W-1:0] i_digit,
    output logic               o_en,
    output logic               o_carry,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic               r_carry;
    logic               r_en;
    logic [DIGIT_W:0]   w_sum;
    logic               w_ge;
    logic [DIGIT_W-1:0] n_digit;

    // 2*d + c, reduced once: d < radix keeps the sum below 2*radix
    assign w_sum   = {r_digit, i_carry};
    assign w_ge    = (w_sum >= i_radix);
    always_comb begin
        n_digit = w_ge ? DIGIT_W'(w_sum - i_radix) : DIGIT_W'(w_sum);
    end

    // Conversion wavefront token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else begin
            r_en <= i_en && !i_ctrl.clear;
        end
    end

    // Digit and carry toward the next cell
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.shift) begin
            r_digit <= i_digit;
        end else if (i_en) begin
            r_digit <= n_digit;
        end
        r_carry <= w_ge;
    end

    assign o_en    = r_en;
    assign o_carry = r_carry;
    assign o_digit = r_digit;

endmodule

@@ design/itrd_checker.sv @@
// Port-level checks for the radix digit converter, bound to the top level.
module itrd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_digit_char,
    input logic [6:0] o_digit_count,
    input logic       o_last
);

    // One item at a time: no new item while digits go out
    a_busy_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("item taken while digits are pending");

    // Digit count is within range on every digit
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_count != 7'd0) && (o_digit_count <= 7'd64))
        else $error("digit count out of range");

    // After a non-final digit the next digit of the same value follows
    a_next_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=>
            (o_out_valid && (o_digit_count == $past(o_digit_count))))
        else $error("digit sequence broken");

    // A stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_digit_char) && $stable(o_digit_count)
             && $stable(o_last)))
        else $error("stalled item changed");

endmodule

bind integer_to_radix_digits_core itrd_checker u_itrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_digit_char  (o_digit_char),
    .o_digit_count (o_digit_count),
    .o_last        (o_last)
);
